// File: rtl/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TICK_CFG_W      = 16;
  localparam int WRAP_W          = 2;
  localparam int ECHO_COUNT_W    = 16;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [TICK_CFG_W-1:0] TRIGGER_TICKS_RST    = 16'd12;
  localparam logic [TICK_CFG_W-1:0] POST_DELAY_TICKS_RST = 16'd10100;
  localparam logic [WRAP_W-1:0]     MAX_OVERFLOWS_RST    = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_MEAS,
    PH_POST
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRIGGER_TICKS,
    CFG_POST_DELAY_TICKS,
    CFG_MAX_OVERFLOWS
  } cfg_index_t;

  typedef struct packed {
    logic [TICK_CFG_W-1:0] trigger_ticks;
    logic [TICK_CFG_W-1:0] post_delay_ticks;
    logic [WRAP_W-1:0]     max_overflows;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic                    trigger_level;
    logic                    busy_res;
    logic                    done_res;
    logic                    status;
    logic [WRAP_W-1:0]       echo_wraps;
    logic [ECHO_COUNT_W-1:0] echo_count;
  } out_t;

endpackage

// File: rtl/uer_cfg.sv
`timescale 1ns / 1ps

module uer_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [uer_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [uer_pkg::TICK_CFG_W-1:0]   wr_data,
  output uer_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks    <= uer_pkg::TRIGGER_TICKS_RST;
      cfg.post_delay_ticks <= uer_pkg::POST_DELAY_TICKS_RST;
      cfg.max_overflows    <= uer_pkg::MAX_OVERFLOWS_RST;
    end else if (wr_en) begin
      case (wr_index)
        uer_pkg::CFG_TRIGGER_TICKS: begin
          cfg.trigger_ticks <= wr_data;
        end
        uer_pkg::CFG_POST_DELAY_TICKS: begin
          cfg.post_delay_ticks <= wr_data;
        end
        uer_pkg::CFG_MAX_OVERFLOWS: begin
          cfg.max_overflows <= wr_data[uer_pkg::WRAP_W-1:0];
        end
        default: begin
          // unmapped index: write is dropped
        end
      endcase
    end
  end

endmodule

// File: rtl/uer_fsm.sv
`timescale 1ns / 1ps

module uer_fsm #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  uer_pkg::in_t  item,
  input  uer_pkg::cfg_t cfg,
  output uer_pkg::out_t res_next
);

  // tick counter serves trigger/settle timing (16 bit) and echo timing
  localparam int TW = (COUNT_WIDTH > uer_pkg::TICK_CFG_W) ? COUNT_WIDTH : uer_pkg::TICK_CFG_W;
  localparam int SW = uer_pkg::TICK_CFG_W + 1;

  uer_pkg::phase_t                     phase, phase_next;
  logic [TW-1:0]                       tick_count, tick_count_next;
  logic [uer_pkg::WRAP_W-1:0]          wrap_count, wrap_count_next;
  logic                                prev_echo;
  logic [uer_pkg::WRAP_W-1:0]          held_wraps, held_wraps_next;
  logic [uer_pkg::ECHO_COUNT_W-1:0]    held_count, held_count_next;
  logic                                held_status, held_status_next;
  logic                                done_next;

  logic                   rise, fall;
  logic [SW-1:0]          step_sum;
  logic [COUNT_WIDTH-1:0] meas_cnt;
  logic [TW-1:0]          meas_ext;
  logic                   meas_wrap;

  assign rise      = item.echo_level & ~prev_echo;
  assign fall      = ~item.echo_level & prev_echo;
  assign step_sum  = {1'b0, tick_count[uer_pkg::TICK_CFG_W-1:0]} + SW'(1);
  assign meas_cnt  = tick_count[COUNT_WIDTH-1:0] + COUNT_WIDTH'(1);
  assign meas_ext  = TW'(meas_cnt);
  assign meas_wrap = (meas_cnt == '0);

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    wrap_count_next  = wrap_count;
    held_wraps_next  = held_wraps;
    held_count_next  = held_count;
    held_status_next = held_status;
    done_next        = 1'b0;
    case (phase)
      uer_pkg::PH_IDLE: begin
        if (item.start_req) begin
          phase_next      = uer_pkg::PH_TRIG;
          tick_count_next = '0;
          wrap_count_next = '0;
        end
      end
      uer_pkg::PH_TRIG: begin
        tick_count_next = TW'(step_sum);
        if (step_sum >= {1'b0, cfg.trigger_ticks}) begin
          phase_next      = uer_pkg::PH_WAIT;
          tick_count_next = '0;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (rise) begin
          phase_next      = uer_pkg::PH_MEAS;
          tick_count_next = '0;
          wrap_count_next = '0;
        end
      end
      uer_pkg::PH_MEAS: begin
        tick_count_next = meas_ext;
        if (meas_wrap && (wrap_count >= cfg.max_overflows)) begin
          // timeout wins over a falling edge on the same tick
          phase_next       = uer_pkg::PH_IDLE;
          held_status_next = 1'b1;
          done_next        = 1'b1;
          tick_count_next  = '0;
        end else begin
          if (meas_wrap) begin
            wrap_count_next = wrap_count + uer_pkg::WRAP_W'(1);
          end
          if (fall) begin
            held_count_next  = meas_ext[uer_pkg::ECHO_COUNT_W-1:0];
            held_wraps_next  = wrap_count_next;
            held_status_next = 1'b0;
            tick_count_next  = '0;
            phase_next       = uer_pkg::PH_POST;
          end
        end
      end
      uer_pkg::PH_POST: begin
        tick_count_next = TW'(step_sum);
        if (step_sum >= {1'b0, cfg.post_delay_ticks}) begin
          phase_next      = uer_pkg::PH_IDLE;
          tick_count_next = '0;
          done_next       = 1'b1;
        end
      end
      default: begin
        phase_next = uer_pkg::PH_IDLE;
      end
    endcase

    res_next.trigger_level = (phase_next == uer_pkg::PH_TRIG);
    res_next.busy_res      = (phase_next != uer_pkg::PH_IDLE);
    res_next.done_res      = done_next;
    res_next.status        = held_status_next;
    res_next.echo_wraps    = held_wraps_next;
    res_next.echo_count    = held_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= uer_pkg::PH_IDLE;
      tick_count  <= '0;
      wrap_count  <= '0;
      prev_echo   <= 1'b0;
      held_wraps  <= '0;
      held_count  <= '0;
      held_status <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      wrap_count  <= wrap_count_next;
      prev_echo   <= item.echo_level;
      held_wraps  <= held_wraps_next;
      held_count  <= held_count_next;
      held_status <= held_status_next;
    end
  end

endmodule

// File: rtl/ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps

// Ultrasonic echo ranger: one input transfer per timer tick (start_req, echo_level),
// one result transfer per tick (trigger pin level, busy, done pulse, status,
// latched wrap count and echo width of the last echo).
// Input channel: in_valid/in_ready/in_data. Result channel: out_valid/out_ready/out_data.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; index 0
// trigger_ticks, 1 post_delay_ticks, 2 max_overflows. Write only with no tick in flight.
// Path: an accepted tick is held in the input register, is processed by
// the phase/counter update and lands in the output register, which raises
// out_valid; the result transfer happens while out_ready is high.
// Throughput: 1 tick per cycle while out_ready is high; the phase and counter update is combinational.
// Reset: registers return to 12 / 10100 / 2, phase idle, counters and latched
// results zero, both pipeline registers empty.
// Stall: while out_ready is low the result holds; the input register takes one
// more tick, then in_ready drops until the result transfer happens.
module ultrasonic_echo_ranger_core #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  uer_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output uer_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [uer_pkg::TICK_CFG_W-1:0]  cfg_data
);

  uer_pkg::cfg_t cfg;
  uer_pkg::in_t  s1_item;
  uer_pkg::out_t res_next;
  logic          s1_valid;
  logic          out_free;
  logic          advance;
  logic          in_xfer;

  assign cfg_ready = 1'b1;

  // output slot free when empty or being drained this cycle
  assign out_free = ~out_valid | out_ready;
  assign advance  = s1_valid & out_free;
  assign in_ready = ~s1_valid | out_free;
  assign in_xfer  = in_valid & in_ready;

  uer_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // state advances exactly once per tick, as it moves into the output register
  uer_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (s1_item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_next;
    end
  end

`ifndef SYNTHESIS
  // a ready receiver never back-pressures the input side
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // a done pulse always coincides with the return to idle
  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> (!out_data.busy_res && !out_data.trigger_level))
    else $error("done result while still busy");

  // the trigger pin is only driven during a measurement
  a_trigger_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.trigger_level) |-> out_data.busy_res)
    else $error("trigger driven while idle");

  // the input register only drains into a free output slot, and the drained tick is held there as valid
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed tick lost");
`endif

endmodule
